// ===== rtl/sfh_pkg.sv =====
// Shared types, constants and a helper function for the signed feature hashing block.
// No dependencies; every other file in rtl/ but sfh_ram refers to this package by scoped names.
package sfh_pkg;

	localparam int MAX_DIM    = 512;
	localparam int ADDR_W     = $clog2(MAX_DIM);
	localparam int ACC_W      = 24;
	localparam int SQ_W       = 48;
	localparam int DIM_W      = 10;
	localparam int HASH_W     = 64;
	localparam int TOKEN_W    = 32;
	localparam int SIGN_BIT   = 17;
	localparam int MOD_STEP   = 4;
	localparam int MOD_CYCLES = HASH_W / MOD_STEP;
	localparam int MOD_CNT_W  = $clog2(MOD_CYCLES);

	localparam logic [DIM_W-1:0]  DIM_RESET  = 10'd384;
	localparam logic [HASH_W-1:0] FNV_START  = 64'hcbf29ce484222325;
	localparam logic [SQ_W-1:0]   SQ_MAX     = {SQ_W{1'b1}};
	localparam logic [ACC_W:0]    UNI_WEIGHT = 25'sd10;
	localparam logic [ACC_W:0]    BI_WEIGHT  = 25'sd7;

	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]          mode;
		logic signed [31:0]  token;
		logic [8:0]          index;
	} req_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] value;
		logic [SQ_W-1:0]         norm_squared;
		logic                    saturated;
	} res_t;

	// Multiply by the FNV prime 2^40 + 0x1b3, modulo 2^64, as shifts and adds.
	function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] h);
		fnv_mul = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
	endfunction

endpackage

// ===== rtl/sfh_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
module sfh_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/sfh_fnv.sv =====
// FNV-1a 64-bit hashing of one 32-bit word, one byte per cycle, least significant first.
// Depends on sfh_pkg for widths and the prime multiply.
module sfh_fnv (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [sfh_pkg::HASH_W-1:0] seed,
	input  logic [sfh_pkg::TOKEN_W-1:0] word,
	output logic [sfh_pkg::HASH_W-1:0] hash,
	output logic                       fin
);

	logic [sfh_pkg::HASH_W-1:0]  h_q;
	logic [sfh_pkg::TOKEN_W-1:0] word_q;
	logic [1:0]                  cnt_q;
	logic                        run_q;
	logic                        fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			h_q    <= seed;
			word_q <= word;
		end else if (run_q) begin
			h_q    <= sfh_pkg::fnv_mul(h_q ^ {56'd0, word_q[7:0]});
			word_q <= word_q >> 8;
		end
	end

	assign hash = h_q;
	assign fin  = fin_q;

endmodule

// ===== rtl/sfh_mod.sv =====
// Iterative remainder of a 64-bit hash by the dimension, a few quotient bits per cycle.
// Depends on sfh_pkg for widths and the step count.
module sfh_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [sfh_pkg::HASH_W-1:0] dividend,
	input  logic [sfh_pkg::DIM_W-1:0]  divisor,
	output logic [sfh_pkg::ADDR_W-1:0] rem,
	output logic                       fin
);

	logic [sfh_pkg::HASH_W-1:0]    num_q;
	logic [sfh_pkg::DIM_W-1:0]     d_q;
	logic [sfh_pkg::DIM_W-1:0]     rem_q;
	logic [sfh_pkg::MOD_CNT_W-1:0] cnt_q;
	logic                          run_q;
	logic                          fin_q;
	logic [sfh_pkg::HASH_W-1:0]    num_n;
	logic [sfh_pkg::DIM_W:0]       r_n;

	// Restoring division steps; the partial remainder stays below the divisor.
	always_comb begin
		num_n = num_q;
		r_n   = {1'b0, rem_q};
		for (int i = 0; i < sfh_pkg::MOD_STEP; i++) begin
			r_n   = {r_n[sfh_pkg::DIM_W-1:0], num_n[sfh_pkg::HASH_W-1]};
			num_n = num_n << 1;
			if (r_n >= {1'b0, d_q}) begin
				r_n = r_n - {1'b0, d_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == sfh_pkg::MOD_CNT_W'(sfh_pkg::MOD_CYCLES - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= dividend;
			d_q   <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= num_n;
			rem_q <= r_n[sfh_pkg::DIM_W-1:0];
		end
	end

	assign rem = rem_q[sfh_pkg::ADDR_W-1:0];
	assign fin = fin_q;

endmodule

// ===== rtl/signed_feature_hashing.sv =====
// Signed feature hashing block: FNV-1a hashed unigram and bigram counts in a RAM store.
// Depends on sfh_pkg, sfh_ram, sfh_fnv and sfh_mod.
// Sequence: an add request hashes the token (S_HASH), reduces the hash by the dimension
// (S_MOD), updates the slot (S_RD), squares (S_SQ1, S_SQ2) and sums (S_SUM), then repeats for a bigram.
// A read request passes S_RDX and S_OUT; a clear writes one RAM row per cycle over the whole store.
// One request is in flight at a time; the receiver cannot stall, done lasts one cycle.
// After reset the block runs a clearing pass over all 512 rows of the store with busy high.
module signed_feature_hashing (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  sfh_pkg::req_t             request,
	output sfh_pkg::res_t             result,
	output logic                      done,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [sfh_pkg::DIM_W-1:0] cfg_data
);

	// Sequencer states.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLR  = 4'd1;
	localparam logic [3:0] S_HASH = 4'd2;
	localparam logic [3:0] S_MOD  = 4'd3;
	localparam logic [3:0] S_RD   = 4'd4;
	localparam logic [3:0] S_SQ1  = 4'd5;
	localparam logic [3:0] S_SQ2  = 4'd6;
	localparam logic [3:0] S_SUM  = 4'd7;
	localparam logic [3:0] S_RDX  = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	localparam int AW  = sfh_pkg::ADDR_W;
	localparam int AC  = sfh_pkg::ACC_W;
	localparam int SQW = sfh_pkg::SQ_W;

	logic [3:0]                   state_q;
	logic [sfh_pkg::DIM_W-1:0]    dim_q;
	logic [AW-1:0]                clr_cnt_q;
	logic                         emit_q;
	sfh_pkg::req_t                req_q;
	logic                         phase_bi_q;
	logic [sfh_pkg::HASH_W-1:0]   hash_q;
	logic [sfh_pkg::HASH_W-1:0]   uni_hash_q;
	logic [sfh_pkg::HASH_W-1:0]   prev_hash_q;
	logic                         have_prev_q;
	logic [AW-1:0]                slot_q;
	logic [AW-1:0]                uni_slot_q;
	logic signed [AC-1:0]         out_val_q;
	logic signed [AC-1:0]         old_q;
	logic signed [AC-1:0]         new_q;
	logic [SQW-1:0]               sqn_q;
	logic [SQW-1:0]               sqo_q;
	logic [SQW-1:0]               sum_q;
	logic                         sat_q;
	sfh_pkg::res_t                result_q;
	logic                         done_q;

	logic [sfh_pkg::DIM_W-1:0]    eff_dim;
	logic                         fnv_go;
	logic [sfh_pkg::HASH_W-1:0]   fnv_seed;
	logic [sfh_pkg::HASH_W-1:0]   fnv_hash;
	logic                         fnv_fin;
	logic                         mod_go;
	logic [AW-1:0]                mod_rem;
	logic                         mod_fin;
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [AC-1:0]                ram_wdata;
	logic                         ram_re;
	logic [AW-1:0]                ram_raddr;
	logic [AC-1:0]                ram_rdata;
	logic signed [AC:0]           amount;
	logic signed [AC:0]           sum_t;
	logic signed [AC-1:0]         clamped;
	logic                         clamp_hit;
	logic signed [AC-1:0]         sq_in;
	logic [AC-1:0]                sq_mag;
	logic [SQW-1:0]               sq_prod;
	logic [SQW+1:0]               sum_next;
	logic                         accept;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	// The dimension only changes between requests; a request offered in the same cycle
	// goes first, so a request never sees the dimension move while it is in flight.
	assign cfg_ready = !busy && !start;

	// A zero dimension acts as one; anything above the store depth is capped.
	always_comb begin
		if (dim_q == '0) begin
			eff_dim = sfh_pkg::DIM_W'(1);
		end else if (dim_q > sfh_pkg::DIM_W'(sfh_pkg::MAX_DIM)) begin
			eff_dim = sfh_pkg::DIM_W'(sfh_pkg::MAX_DIM);
		end else begin
			eff_dim = dim_q;
		end
	end

	// The unigram hash starts from the FNV offset basis; the bigram hash continues from
	// the previous token's unigram hash, which equals hashing that token's bytes first.
	assign fnv_go   = (accept && request.mode == sfh_pkg::MODE_ADD) ||
	                  (state_q == S_SUM && !phase_bi_q && have_prev_q);
	assign fnv_seed = (state_q == S_SUM) ? prev_hash_q : sfh_pkg::FNV_START;
	assign mod_go   = (state_q == S_HASH) && fnv_fin;

	sfh_fnv u_fnv (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (fnv_go),
		.seed   (fnv_seed),
		.word   ((state_q == S_SUM) ? req_q.token : request.token),
		.hash   (fnv_hash),
		.fin    (fnv_fin)
	);

	sfh_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (mod_go),
		.dividend (fnv_hash),
		.divisor  (eff_dim),
		.rem      (mod_rem),
		.fin      (mod_fin)
	);

	// Reads of the store happen only after the previous write has landed, so the
	// read-modify-write needs no forwarding path.
	assign ram_re    = (accept && request.mode == sfh_pkg::MODE_READ) ||
	                   (state_q == S_MOD && mod_fin);
	assign ram_raddr = (state_q == S_IDLE) ? AW'(request.index) : mod_rem;
	assign ram_we    = (state_q == S_CLR) || (state_q == S_RD);
	assign ram_waddr = (state_q == S_CLR) ? clr_cnt_q : slot_q;
	assign ram_wdata = (state_q == S_CLR) ? '0 : clamped;

	sfh_ram #(
		.DEPTH (sfh_pkg::MAX_DIM),
		.WIDTH (AC)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Signed add with clamping to the accumulator range; hash bit 17 picks the sign.
	always_comb begin
		amount = phase_bi_q ? sfh_pkg::BI_WEIGHT : sfh_pkg::UNI_WEIGHT;
		if (hash_q[sfh_pkg::SIGN_BIT]) begin
			amount = -amount;
		end
		sum_t     = $signed({ram_rdata[AC-1], ram_rdata}) + amount;
		clamp_hit = 1'b0;
		clamped   = sum_t[AC-1:0];
		if (sum_t > $signed({2'b00, {(AC-1){1'b1}}})) begin
			clamped   = {1'b0, {(AC-1){1'b1}}};
			clamp_hit = 1'b1;
		end else if (sum_t < $signed({2'b11, {(AC-1){1'b0}}})) begin
			clamped   = {1'b1, {(AC-1){1'b0}}};
			clamp_hit = 1'b1;
		end
	end

	// One shared squarer: new value in S_SQ1, old value in S_SQ2.
	always_comb begin
		sq_in   = (state_q == S_SQ1) ? new_q : old_q;
		sq_mag  = sq_in[AC-1] ? AC'(-sq_in) : AC'(sq_in);
		sq_prod = SQW'(sq_mag) * SQW'(sq_mag);
	end

	// The running sum already holds the old square, so the difference never goes negative.
	assign sum_next = {2'b00, sum_q} + {2'b00, sqn_q} - {2'b00, sqo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_cnt_q   <= '0;
			emit_q      <= 1'b0;
			dim_q       <= sfh_pkg::DIM_RESET;
			have_prev_q <= 1'b0;
			sum_q       <= '0;
			sat_q       <= 1'b0;
			done_q      <= 1'b0;
			phase_bi_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				dim_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						case (request.mode)
							sfh_pkg::MODE_ADD: begin
								phase_bi_q <= 1'b0;
								state_q    <= S_HASH;
							end
							sfh_pkg::MODE_READ: begin
								state_q <= S_RDX;
							end
							sfh_pkg::MODE_CLEAR: begin
								clr_cnt_q   <= '0;
								emit_q      <= 1'b1;
								have_prev_q <= 1'b0;
								sum_q       <= '0;
								sat_q       <= 1'b0;
								state_q     <= S_CLR;
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(sfh_pkg::MAX_DIM - 1)) begin
						state_q <= emit_q ? S_OUT : S_IDLE;
					end
				end
				S_HASH: begin
					if (fnv_fin) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_fin) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (clamp_hit) begin
						sat_q <= 1'b1;
					end
					state_q <= S_SQ1;
				end
				S_SQ1: begin
					state_q <= S_SQ2;
				end
				S_SQ2: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					// Once the sum has hit its ceiling it stays there until a clear.
					if (sum_q != sfh_pkg::SQ_MAX) begin
						sum_q <= (sum_next > {2'b00, sfh_pkg::SQ_MAX}) ?
						         sfh_pkg::SQ_MAX : sum_next[SQW-1:0];
					end
					if (!phase_bi_q && have_prev_q) begin
						phase_bi_q <= 1'b1;
						state_q    <= S_HASH;
					end else begin
						have_prev_q <= 1'b1;
						state_q     <= S_OUT;
					end
				end
				S_RDX: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; these carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= request;
			out_val_q <= '0;
		end
		if (state_q == S_HASH && fnv_fin) begin
			hash_q <= fnv_hash;
			if (!phase_bi_q) begin
				uni_hash_q <= fnv_hash;
			end
		end
		if (state_q == S_MOD && mod_fin) begin
			slot_q <= mod_rem;
		end
		if (state_q == S_RD) begin
			old_q <= ram_rdata;
			new_q <= clamped;
			// The reported value is the unigram slot, updated again if the bigram hits it.
			if (!phase_bi_q) begin
				uni_slot_q <= slot_q;
				out_val_q  <= clamped;
			end else if (slot_q == uni_slot_q) begin
				out_val_q <= clamped;
			end
		end
		if (state_q == S_SQ1) begin
			sqn_q <= sq_prod;
		end
		if (state_q == S_SQ2) begin
			sqo_q <= sq_prod;
		end
		if (state_q == S_SUM && !(!phase_bi_q && have_prev_q)) begin
			prev_hash_q <= uni_hash_q;
		end
		if (state_q == S_RDX) begin
			out_val_q <= (32'(req_q.index) < 32'(sfh_pkg::MAX_DIM)) ? ram_rdata : '0;
		end
		if (state_q == S_OUT) begin
			result_q.value        <= out_val_q;
			result_q.norm_squared <= sum_q;
			result_q.saturated    <= sat_q;
		end
	end

	assign result = result_q;
	assign done   = done_q;

	// An accepted request always makes the block busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request did not raise busy");

	// A result strobe only follows the output state and finds the block idle again.
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_OUT) && !busy)
		else $error("done without passing the output state");

	// The update state uses read data, so it must follow the cycle the read was issued.
	a_rd_after_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> ($past(state_q) == S_MOD) && $past(mod_fin))
		else $error("store update without a preceding read");

	// The remainder unit never points past the dimension in use.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD && mod_fin) |-> ({1'b0, mod_rem} < {1'b0, eff_dim}))
		else $error("hash slot outside the dimension");

endmodule
